[rtl/load_cell_sample_qualifier_macros.svh]
// Assertion macros shared by the load cell sample qualifier RTL.
`ifndef LOAD_CELL_SAMPLE_QUALIFIER_MACROS_SVH
`define LOAD_CELL_SAMPLE_QUALIFIER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LCSQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcsq assertion failed");

// Next-cycle implication, disabled during reset.
`define LCSQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcsq assertion failed");

`endif

[rtl/lcsq_pkg.sv]
// Shared types, codes and constants of the load cell sample qualifier.
`default_nettype none
package lcsq_pkg;

  localparam int RAW_WIDTH_DEF = 24;

  // command codes
  localparam logic [1:0] CMD_POLL        = 2'd0;
  localparam logic [1:0] CMD_RESTART     = 2'd1;
  localparam logic [1:0] CMD_REINIT_DONE = 2'd2;

  // result status codes
  localparam logic [2:0] ST_SKIPPED   = 3'd0;
  localparam logic [2:0] ST_OK        = 3'd1;
  localparam logic [2:0] ST_WARMING   = 3'd2;
  localparam logic [2:0] ST_NOT_READY = 3'd3;
  localparam logic [2:0] ST_INVALID   = 3'd4;
  localparam logic [2:0] ST_JUMP      = 3'd5;
  localparam logic [2:0] ST_CMD_DONE  = 3'd6;

  // register indexes
  localparam logic [2:0] REG_SAMPLE_INTERVAL = 3'd0;
  localparam logic [2:0] REG_TARE_OFFSET     = 3'd1;
  localparam logic [2:0] REG_GRAMS_PER_COUNT = 3'd2;
  localparam logic [2:0] REG_FILTER_SAMPLES  = 3'd3;
  localparam logic [2:0] REG_STARTUP         = 3'd4;

  // register reset values
  localparam logic [15:0] SAMPLE_INTERVAL_RST = 16'd100;
  localparam logic [31:0] GRAMS_PER_COUNT_RST = 32'h0100_0000;
  localparam logic [5:0]  FILTER_SAMPLES_RST  = 6'd10;

  // timing and limits
  localparam logic [31:0] WARMUP_MS      = 32'd5000;
  localparam logic [31:0] SETTLE_MS      = 32'd3000;
  localparam logic [31:0] REINIT_GAP_MS  = 32'd30000;
  localparam logic [7:0]  ERR_LIMIT      = 8'd5;
  localparam logic [7:0]  ERR_MAX        = 8'd255;
  localparam int          JUMP_LIMIT     = 500000;
  localparam int          NEAR_ZERO      = 10;
  localparam int          STABLE_BAND    = 1280;   // 5 g in Q24.8

  localparam int ALPHA_W = 17;
  localparam int DELTA_W = 33;
  localparam int PROD2_W = DELTA_W + ALPHA_W + 1;

  // EMA weight round(2^17/(N+1)) in Q1.16, indexed by the raw register value;
  // out of range spans clamp to 1 and 50.
  localparam logic [ALPHA_W-1:0] ALPHA_TABLE [64] = '{
    17'd65536, 17'd65536, 17'd43691, 17'd32768, 17'd26214, 17'd21845, 17'd18725, 17'd16384,
    17'd14564, 17'd13107, 17'd11916, 17'd10923, 17'd10082, 17'd9362,  17'd8738,  17'd8192,
    17'd7710,  17'd7282,  17'd6899,  17'd6554,  17'd6242,  17'd5958,  17'd5699,  17'd5461,
    17'd5243,  17'd5041,  17'd4855,  17'd4681,  17'd4520,  17'd4369,  17'd4228,  17'd4096,
    17'd3972,  17'd3855,  17'd3745,  17'd3641,  17'd3542,  17'd3449,  17'd3361,  17'd3277,
    17'd3197,  17'd3121,  17'd3048,  17'd2979,  17'd2913,  17'd2849,  17'd2789,  17'd2731,
    17'd2675,  17'd2621,  17'd2570,  17'd2570,  17'd2570,  17'd2570,  17'd2570,  17'd2570,
    17'd2570,  17'd2570,  17'd2570,  17'd2570,  17'd2570,  17'd2570,  17'd2570,  17'd2570
  };

  typedef struct packed {
    logic load;
    logic mul1;
    logic rnd1;
    logic delta;
    logic mul2;
    logic rnd2;
    logic commit;
  } lcsq_cmd_t;

  typedef struct packed {
    logic out_free;
  } lcsq_stat_t;

endpackage
`default_nettype wire

[rtl/lcsq_ctrl.sv]
// Sequencer that steps one request through the datapath stages.
`default_nettype none
module lcsq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               sample_valid,
  output logic                    sample_stall,
  input  wire lcsq_pkg::lcsq_stat_t stat,
  output lcsq_pkg::lcsq_cmd_t     cmd
);
  import lcsq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL1   = 3'd1;
  localparam logic [2:0] S_RND1   = 3'd2;
  localparam logic [2:0] S_DELTA  = 3'd3;
  localparam logic [2:0] S_MUL2   = 3'd4;
  localparam logic [2:0] S_RND2   = 3'd5;
  localparam logic [2:0] S_COMMIT = 3'd6;

  logic [2:0] state, state_next;

  assign sample_stall = rst || (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (sample_valid && !sample_stall) begin
          cmd.load   = 1'b1;
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_RND1;
      end
      S_RND1: begin
        cmd.rnd1   = 1'b1;
        state_next = S_DELTA;
      end
      S_DELTA: begin
        cmd.delta  = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_RND2;
      end
      S_RND2: begin
        cmd.rnd2   = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the result register can take the new result
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

[rtl/lcsq_datapath.sv]
// Registers, scaling multiplier, EMA multiplier, qualification and result register.
`default_nettype none
module lcsq_datapath #(
  parameter int RAW_WIDTH = lcsq_pkg::RAW_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [31:0]           cfg_data,
  input  wire lcsq_pkg::lcsq_cmd_t   cmd,
  output lcsq_pkg::lcsq_stat_t       stat,
  input  wire logic [1:0]            command,
  input  wire logic [31:0]           now_ms,
  input  wire logic                  sensor_ready,
  input  wire logic signed [RAW_WIDTH-1:0] raw_sample,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output logic [2:0]                 status,
  output logic signed [31:0]         weight,
  output logic                       weight_valid,
  output logic                       weight_stable,
  output logic signed [RAW_WIDTH-1:0] last_raw_value,
  output logic [7:0]                 error_tally,
  output logic                       reinit_request
);
  import lcsq_pkg::*;

  localparam int DW   = RAW_WIDTH + 1;
  localparam int PW1  = DW + 32;
  localparam int R1W  = PW1 - 16;
  localparam int JW   = (RAW_WIDTH + 1 > 21) ? RAW_WIDTH + 1 : 21;
  localparam int R2W  = PROD2_W - 16;

  // configuration
  logic [15:0]                 sample_interval;
  logic signed [RAW_WIDTH-1:0] tare_offset;
  logic signed [31:0]          grams_per_count;
  logic [5:0]                  filter_samples;
  logic [31:0]                 startup_ms;

  // block state
  logic [31:0]                 last_poll_time;
  logic signed [RAW_WIDTH-1:0] previous_raw;
  logic signed [31:0]          filtered_weight;
  logic                        awaiting_first;
  logic                        settle_running;
  logic [31:0]                 settle_start_time;
  logic                        stable_mark;
  logic                        valid_mark;
  logic [7:0]                  error_counter;
  logic [31:0]                 last_reinit_time;

  // request and stage registers
  logic [1:0]                  item_cmd;
  logic [31:0]                 item_now;
  logic                        item_ready;
  logic signed [RAW_WIDTH-1:0] item_raw;
  logic signed [DW-1:0]        diff;
  logic signed [PW1-1:0]       prod1;
  logic [ALPHA_W-1:0]          alpha;
  logic                        due_flag, warm_flag, near_zero, jump_flag;
  logic                        reinit_ok, settle_elapsed;
  logic signed [31:0]          g;
  logic                        g_ok;
  logic signed [DELTA_W-1:0]   delta;
  logic signed [PROD2_W-1:0]   prod2;
  logic                        small_delta;
  logic signed [31:0]          ema;
  logic                        small_r2;

  // stage logic
  logic signed [JW-1:0]        jump_diff;
  logic signed [PW1-1:0]       sum1;
  logic signed [R1W-1:0]       r1w;
  logic signed [PROD2_W-1:0]   sum2;
  logic signed [R2W-1:0]       r2w;
  logic signed [31:0]          r2;

  // commit logic
  logic [2:0]                  status_next;
  logic                        req_next;
  logic [31:0]                 last_poll_next;
  logic signed [RAW_WIDTH-1:0] prev_next;
  logic signed [31:0]          filt_next;
  logic                        await_next, run_next, stable_next, valid_next;
  logic [31:0]                 start_next, reinit_next;
  logic [7:0]                  err_next, err_inc;
  logic                        err_path, step_small;

  assign stat.out_free = !result_valid || !result_stall;

  assign jump_diff = JW'(item_raw) - JW'(previous_raw);
  assign sum1 = prod1 + $signed({{(PW1-16){1'b0}}, (prod1[PW1-1] ? 16'h7FFF : 16'h8000)});
  assign r1w  = sum1[PW1-1:16];
  assign sum2 = prod2 + $signed({{(PROD2_W-16){1'b0}}, (prod2[PROD2_W-1] ? 16'h7FFF : 16'h8000)});
  assign r2w  = sum2[PROD2_W-1:16];
  // a correction that does not fit in 32 bits counts as zero
  assign r2   = (r2w[R2W-1:31] == {(R2W-31){r2w[31]}}) ? r2w[31:0] : 32'sd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_interval <= SAMPLE_INTERVAL_RST;
      tare_offset     <= '0;
      grams_per_count <= GRAMS_PER_COUNT_RST;
      filter_samples  <= FILTER_SAMPLES_RST;
      startup_ms      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_INTERVAL: sample_interval <= cfg_data[15:0];
        REG_TARE_OFFSET:     tare_offset     <= cfg_data[RAW_WIDTH-1:0];
        REG_GRAMS_PER_COUNT: grams_per_count <= cfg_data;
        REG_FILTER_SAMPLES:  filter_samples  <= cfg_data[5:0];
        REG_STARTUP:         startup_ms      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_cmd   <= command;
      item_now   <= now_ms;
      item_ready <= sensor_ready;
      item_raw   <= raw_sample;
      diff       <= DW'(raw_sample) - DW'(tare_offset);
    end
    if (cmd.mul1) begin
      prod1          <= PW1'(diff) * PW1'(grams_per_count);
      alpha          <= ALPHA_TABLE[filter_samples];
      due_flag       <= (item_now - last_poll_time) >= {16'd0, sample_interval};
      warm_flag      <= (item_now - startup_ms) < WARMUP_MS;
      near_zero      <= (item_raw < RAW_WIDTH'(NEAR_ZERO)) && (item_raw > -RAW_WIDTH'(NEAR_ZERO));
      jump_flag      <= (jump_diff > JW'(JUMP_LIMIT)) || (jump_diff < -JW'(JUMP_LIMIT));
      reinit_ok      <= (item_now - last_reinit_time) >= REINIT_GAP_MS;
      settle_elapsed <= (item_now - settle_start_time) >= SETTLE_MS;
    end
    if (cmd.rnd1) begin
      g    <= r1w[31:0];
      g_ok <= r1w[R1W-1:31] == {(R1W-31){r1w[31]}};
    end
    if (cmd.delta) begin
      delta <= DELTA_W'(g) - DELTA_W'(filtered_weight);
    end
    if (cmd.mul2) begin
      prod2       <= PROD2_W'(delta) * $signed({{(PROD2_W-ALPHA_W){1'b0}}, alpha});
      small_delta <= (delta < DELTA_W'(STABLE_BAND)) && (delta > -DELTA_W'(STABLE_BAND));
    end
    if (cmd.rnd2) begin
      ema      <= filtered_weight + r2;
      small_r2 <= (r2 < 32'sd1280) && (r2 > -32'sd1280);
    end
  end

  always_comb begin
    status_next    = ST_SKIPPED;
    req_next       = 1'b0;
    last_poll_next = last_poll_time;
    prev_next      = previous_raw;
    filt_next      = filtered_weight;
    await_next     = awaiting_first;
    run_next       = settle_running;
    start_next     = settle_start_time;
    stable_next    = stable_mark;
    valid_next     = valid_mark;
    err_next       = error_counter;
    reinit_next    = last_reinit_time;
    err_inc        = (error_counter == ERR_MAX) ? error_counter : error_counter + 8'd1;
    err_path       = 1'b0;
    step_small     = awaiting_first ? small_delta : small_r2;
    case (item_cmd)
      CMD_RESTART: begin
        filt_next   = '0;
        await_next  = 1'b1;
        run_next    = 1'b0;
        valid_next  = 1'b1;
        stable_next = 1'b0;
        status_next = ST_CMD_DONE;
      end
      CMD_REINIT_DONE: begin
        err_next    = '0;
        filt_next   = '0;
        await_next  = 1'b1;
        status_next = ST_CMD_DONE;
      end
      CMD_POLL: begin
        if (due_flag) begin
          last_poll_next = item_now;
          if (!item_ready) begin
            if (warm_flag) begin
              valid_next  = 1'b0;
              stable_next = 1'b0;
              status_next = ST_WARMING;
            end else begin
              status_next = ST_NOT_READY;
              err_path    = 1'b1;
            end
          end else begin
            prev_next = item_raw;
            if (!g_ok || near_zero) begin
              status_next = ST_INVALID;
              err_path    = 1'b1;
            end else if (!awaiting_first && jump_flag) begin
              status_next = ST_JUMP;
              err_path    = 1'b1;
            end else begin
              valid_next  = 1'b1;
              err_next    = '0;
              status_next = ST_OK;
              await_next  = 1'b0;
              filt_next   = awaiting_first ? g : ema;
              if (step_small) begin
                if (!settle_running) begin
                  run_next   = 1'b1;
                  start_next = item_now;
                end
              end else begin
                run_next = 1'b0;
              end
              // a timer started on this sample has zero elapsed time
              stable_next = run_next && settle_running && settle_elapsed;
            end
          end
        end
      end
      default: ;
    endcase
    if (err_path) begin
      err_next    = err_inc;
      valid_next  = 1'b0;
      stable_next = 1'b0;
      if ((err_inc >= ERR_LIMIT) && reinit_ok) begin
        reinit_next = item_now;
        req_next    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_poll_time    <= '0;
      previous_raw      <= '0;
      filtered_weight   <= '0;
      awaiting_first    <= 1'b1;
      settle_running    <= 1'b0;
      settle_start_time <= '0;
      stable_mark       <= 1'b0;
      valid_mark        <= 1'b0;
      error_counter     <= '0;
      last_reinit_time  <= '0;
    end else if (cmd.commit) begin
      last_poll_time    <= last_poll_next;
      previous_raw      <= prev_next;
      filtered_weight   <= filt_next;
      awaiting_first    <= await_next;
      settle_running    <= run_next;
      settle_start_time <= start_next;
      stable_mark       <= stable_next;
      valid_mark        <= valid_next;
      error_counter     <= err_next;
      last_reinit_time  <= reinit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status         <= status_next;
      weight         <= filt_next;
      weight_valid   <= valid_next;
      weight_stable  <= valid_next && stable_next;
      last_raw_value <= prev_next;
      error_tally    <= err_next;
      reinit_request <= req_next;
    end
  end

endmodule
`default_nettype wire

[rtl/load_cell_sample_qualifier.sv]
// Top level of the load cell sample qualifier: sequencer, datapath and checks.
//
//   channel   direction  handshake                    payload
//   sample    in         sample_valid / sample_stall  command, now_ms, sensor_ready, raw_sample
//   result    out        result_valid / result_stall  status, weight, flags, raw, tally, reinit
//   cfg       in         cfg_valid / cfg_ready        cfg_index, cfg_data
//
// Each request steps through the accept, then scale multiply, round,
// EMA difference, EMA multiply, round, and the commit that updates state.
// The commit waits while the result register holds an untaken result.
// rst is synchronous; it restores the register defaults and the idle state.
// cfg_ready is always high; registers are written only while idle (a rule for the user: the block does not enforce it).
`default_nettype none
`include "load_cell_sample_qualifier_macros.svh"
module load_cell_sample_qualifier #(
  parameter int RAW_WIDTH = lcsq_pkg::RAW_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   sample_valid,
  output logic                        sample_stall,
  input  wire logic [1:0]             command,
  input  wire logic [31:0]            now_ms,
  input  wire logic                   sensor_ready,
  input  wire logic signed [RAW_WIDTH-1:0] raw_sample,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output logic [2:0]                  status,
  output logic signed [31:0]          weight,
  output logic                        weight_valid,
  output logic                        weight_stable,
  output logic signed [RAW_WIDTH-1:0] last_raw_value,
  output logic [7:0]                  error_tally,
  output logic                        reinit_request,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [31:0]            cfg_data
);
  import lcsq_pkg::*;

  lcsq_cmd_t  cmd;
  lcsq_stat_t stat;
  logic       cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  lcsq_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  lcsq_datapath #(
    .RAW_WIDTH (RAW_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .stat           (stat),
    .command        (command),
    .now_ms         (now_ms),
    .sensor_ready   (sensor_ready),
    .raw_sample     (raw_sample),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .status         (status),
    .weight         (weight),
    .weight_valid   (weight_valid),
    .weight_stable  (weight_stable),
    .last_raw_value (last_raw_value),
    .error_tally    (error_tally),
    .reinit_request (reinit_request)
  );

  // one request at a time: no accept right after an accept
  `LCSQ_ASSERT_NEXT(a_one_at_a_time, clk, rst, sample_valid && !sample_stall, sample_stall)
  // a reinit request only comes with enough counted errors
  `LCSQ_ASSERT_IMPL(a_reinit_needs_errors, clk, rst, result_valid && reinit_request, error_tally >= ERR_LIMIT)
  // a good sample clears the tally and marks the weight valid
  `LCSQ_ASSERT_IMPL(a_ok_is_clean, clk, rst, result_valid && (status == ST_OK), weight_valid && (error_tally == 8'd0))
  // a fault drops validity and counts
  `LCSQ_ASSERT_IMPL(a_fault_counts, clk, rst, result_valid && ((status == ST_NOT_READY) || (status == ST_INVALID) || (status == ST_JUMP)), !weight_valid && (error_tally != 8'd0))

endmodule
`default_nettype wire
